[rtl/s2b_pkg.sv]
package s2b_pkg;

  // Saturation bounds of the size registers.
  localparam int MAX_BATCHES = 64;
  localparam int MAX_DIM     = 4096;
  localparam int MAX_BLOCK   = 16;

  // Port widths.
  localparam int OB_W      = 14;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 12;
  localparam int DIM_W     = 12;
  localparam int PIX_W     = 30;
  localparam int FILL_W    = 8;
  localparam int BLK_W     = 5;
  localparam int PAD_W     = 8;
  localparam int NB_W      = 7;
  localparam int SIZE_W    = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Internal widths derived from the bounds.
  localparam int QBITS     = $clog2(MAX_BLOCK);
  localparam int SB_W      = $clog2(MAX_BATCHES);
  localparam int NBW_W     = $clog2(MAX_BATCHES * MAX_BLOCK + 1);
  localparam int TOTAL_W   = $clog2(MAX_BATCHES * MAX_BLOCK * MAX_BLOCK + 1);
  localparam int DIV_W     = NBW_W + QBITS;
  localparam int POS_W     = ROW_W + QBITS;
  localparam int ROWIDX_W  = SB_W + SIZE_W + 1;
  localparam int PROD_W    = ROWIDX_W + SIZE_W;

  // Pipeline stage positions.
  localparam int ST_IN   = 0;
  localparam int ST_DIV1 = ST_IN + 1;
  localparam int ST_DIV2 = ST_DIV1 + QBITS;
  localparam int ST_POS  = ST_DIV2 + QBITS;
  localparam int ST_CHK  = ST_POS + 1;
  localparam int ST_ROW  = ST_CHK + 1;
  localparam int ST_PIX  = ST_ROW + 1;
  localparam int NSTG    = ST_PIX + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_HEIGHT = 3'd0,
    REG_BLOCK_WIDTH  = 3'd1,
    REG_PAD_TOP      = 3'd2,
    REG_LEFT_PAD     = 3'd3,
    REG_NUM_BATCHES  = 3'd4,
    REG_SRC_HEIGHT   = 3'd5,
    REG_SRC_WIDTH    = 3'd6,
    REG_FILL_VALUE   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [OB_W-1:0]     ob;
    logic [ROW_W-1:0]    orow;
    logic [COL_W-1:0]    ocol;
    logic [OB_W-1:0]     rem;
    logic [QBITS-1:0]    q1;
    logic [QBITS-1:0]    q2;
    logic [POS_W-1:0]    rpos;
    logic [POS_W-1:0]    cpos;
    logic                pad;
    logic [DIM_W-1:0]    sr;
    logic [DIM_W-1:0]    sc;
    logic [ROWIDX_W-1:0] row_idx;
    logic [PIX_W-1:0]    pix;
    logic [FILL_W-1:0]   fill;
  } stage_t;

endpackage

[rtl/space_to_batch_address_map.sv]
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_stall  | out_batch, out_row, out_col
// result    | out_valid / out_stall| is_pad, src_batch, src_row, src_col,
//           |                      | src_pixel_index, pad_value
// config    | cfg_we               | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low. Each item passes through the
// capture stage, the two divider chains of one bit per stage, and the position,
// check, row and pixel stages in that order; the result is offered from the pixel
// stage and leaves when out_stall is low.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// Each stage holds its item while the next one is full and cannot move, so empty
// stages are filled up behind a stalled result; in_stall rises only when all are full.
module space_to_batch_address_map
  import s2b_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OB_W-1:0]      out_batch,
  input  logic [ROW_W-1:0]     out_row,
  input  logic [COL_W-1:0]     out_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 is_pad,
  output logic [SB_W-1:0]      src_batch,
  output logic [DIM_W-1:0]     src_row,
  output logic [DIM_W-1:0]     src_col,
  output logic [PIX_W-1:0]     src_pixel_index,
  output logic [FILL_W-1:0]    pad_value
);

  logic [BLK_W-1:0]  block_height, block_width;
  logic [PAD_W-1:0]  pad_top, left_pad;
  logic [NB_W-1:0]   num_batches;
  logic [SIZE_W-1:0] src_height, src_width;
  logic [FILL_W-1:0] fill_value;

  logic [BLK_W-1:0]  bh_s, bw_s;
  logic [NB_W-1:0]   nb_s;
  logic [SIZE_W-1:0] ih_s, iw_s;

  logic [NBW_W-1:0]   nbw;
  logic [TOTAL_W-1:0] total;

  stage_t            pipe [NSTG];
  stage_t            src  [NSTG];
  stage_t            nxt  [NSTG];
  logic [NSTG-1:0]   pipe_v, src_v, adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_height <= BLK_W'(2);
      block_width  <= BLK_W'(2);
      pad_top      <= '0;
      left_pad     <= '0;
      num_batches  <= NB_W'(1);
      src_height   <= SIZE_W'(1);
      src_width    <= SIZE_W'(1);
      fill_value   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_HEIGHT: block_height <= cfg_data[BLK_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BLK_W-1:0];
        REG_PAD_TOP:      pad_top      <= cfg_data[PAD_W-1:0];
        REG_LEFT_PAD:     left_pad     <= cfg_data[PAD_W-1:0];
        REG_NUM_BATCHES:  num_batches  <= cfg_data[NB_W-1:0];
        REG_SRC_HEIGHT:   src_height   <= cfg_data[SIZE_W-1:0];
        REG_SRC_WIDTH:    src_width    <= cfg_data[SIZE_W-1:0];
        REG_FILL_VALUE:   fill_value   <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // Block sizes, batch count and source sizes are clamped into their legal ranges before use.
  always_comb begin
    if (block_height < BLK_W'(2)) bh_s = BLK_W'(2);
    else if (32'(block_height) > MAX_BLOCK) bh_s = BLK_W'(MAX_BLOCK);
    else bh_s = block_height;

    if (block_width < BLK_W'(2)) bw_s = BLK_W'(2);
    else if (32'(block_width) > MAX_BLOCK) bw_s = BLK_W'(MAX_BLOCK);
    else bw_s = block_width;

    if (num_batches == '0) nb_s = NB_W'(1);
    else if (32'(num_batches) > MAX_BATCHES) nb_s = NB_W'(MAX_BATCHES);
    else nb_s = num_batches;

    if (src_height == '0) ih_s = SIZE_W'(1);
    else if (32'(src_height) > MAX_DIM) ih_s = SIZE_W'(MAX_DIM);
    else ih_s = src_height;

    if (src_width == '0) iw_s = SIZE_W'(1);
    else if (32'(src_width) > MAX_DIM) iw_s = SIZE_W'(MAX_DIM);
    else iw_s = src_width;
  end

  // Batches times block width, and the number of output batches. The user must change
  // registers only while no item is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      nbw   <= NBW_W'(2);
      total <= TOTAL_W'(4);
    end else begin
      nbw   <= NBW_W'(NBW_W'(nb_s) * NBW_W'(bw_s));
      total <= TOTAL_W'(TOTAL_W'(nbw) * TOTAL_W'(bh_s));
    end
  end

  always_comb begin
    src[ST_IN]      = '0;
    src[ST_IN].ob   = out_batch;
    src[ST_IN].rem  = out_batch;
    src[ST_IN].orow = out_row;
    src[ST_IN].ocol = out_col;
    src_v[ST_IN]    = in_valid;
    for (int s = 1; s < NSTG; s++) begin
      src[s]   = pipe[s-1];
      src_v[s] = pipe_v[s-1];
    end
  end

  always_comb begin
    adv[NSTG-1] = !pipe_v[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      adv[s] = !pipe_v[s] || adv[s+1];
    end
  end

  // The tile index is split by dividing first by batches*block_width (giving the
  // tile row) and then the remainder by batches (tile column, source batch).
  always_comb begin
    logic [DIV_W-1:0]  dsh;
    logic [POS_W-1:0]  rdiff, cdiff;
    logic              row_ok, col_ok;
    logic [PROD_W-1:0] prod;
    dsh   = '0;
    rdiff = '0;
    cdiff = '0;
    row_ok = 1'b0;
    col_ok = 1'b0;
    prod  = '0;
    for (int s = 0; s < NSTG; s++) begin
      nxt[s] = src[s];
      if (s >= ST_DIV1 && s < ST_DIV2) begin
        dsh = DIV_W'(nbw) << (ST_DIV2 - 1 - s);
        if (DIV_W'(src[s].rem) >= dsh) begin
          nxt[s].rem = OB_W'(DIV_W'(src[s].rem) - dsh);
          nxt[s].q1  = QBITS'({src[s].q1, 1'b1});
        end else begin
          nxt[s].q1  = QBITS'({src[s].q1, 1'b0});
        end
      end else if (s >= ST_DIV2 && s < ST_POS) begin
        dsh = DIV_W'(nb_s) << (ST_POS - 1 - s);
        if (DIV_W'(src[s].rem) >= dsh) begin
          nxt[s].rem = OB_W'(DIV_W'(src[s].rem) - dsh);
          nxt[s].q2  = QBITS'({src[s].q2, 1'b1});
        end else begin
          nxt[s].q2  = QBITS'({src[s].q2, 1'b0});
        end
      end else if (s == ST_POS) begin
        nxt[s].pad  = 32'(src[s].ob) >= 32'(total);
        nxt[s].rpos = POS_W'(POS_W'(src[s].orow) * POS_W'(bh_s) + POS_W'(src[s].q1));
        nxt[s].cpos = POS_W'(POS_W'(src[s].ocol) * POS_W'(bw_s) + POS_W'(src[s].q2));
      end else if (s == ST_CHK) begin
        rdiff  = src[s].rpos - POS_W'(pad_top);
        cdiff  = src[s].cpos - POS_W'(left_pad);
        row_ok = (src[s].rpos >= POS_W'(pad_top)) && (rdiff < POS_W'(ih_s));
        col_ok = (src[s].cpos >= POS_W'(left_pad)) && (cdiff < POS_W'(iw_s));
        nxt[s].pad     = src[s].pad || !row_ok || !col_ok;
        nxt[s].sr      = rdiff[DIM_W-1:0];
        nxt[s].sc      = cdiff[DIM_W-1:0];
        nxt[s].row_idx = ROWIDX_W'(src[s].rem[SB_W-1:0]) * ROWIDX_W'(ih_s);
      end else if (s == ST_ROW) begin
        nxt[s].row_idx = src[s].row_idx + ROWIDX_W'(src[s].sr);
      end else if (s == ST_PIX) begin
        prod = PROD_W'(src[s].row_idx) * PROD_W'(iw_s) + PROD_W'(src[s].sc);
        if (src[s].pad) begin
          nxt[s].rem  = '0;
          nxt[s].sr   = '0;
          nxt[s].sc   = '0;
          nxt[s].pix  = '0;
          nxt[s].fill = fill_value;
        end else begin
          nxt[s].pix  = prod[PIX_W-1:0];
          nxt[s].fill = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (adv[s]) begin
          pipe_v[s] <= src_v[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (adv[s] && src_v[s]) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  assign in_stall        = !adv[ST_IN];
  assign out_valid       = pipe_v[NSTG-1];
  assign is_pad          = pipe[NSTG-1].pad;
  assign src_batch       = pipe[NSTG-1].rem[SB_W-1:0];
  assign src_row         = pipe[NSTG-1].sr;
  assign src_col         = pipe[NSTG-1].sc;
  assign src_pixel_index = pipe[NSTG-1].pix;
  assign pad_value       = pipe[NSTG-1].fill;

endmodule

[rtl/s2b_checker.sv]
module s2b_checker
  import s2b_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 is_pad,
  input logic [SB_W-1:0]      src_batch,
  input logic [DIM_W-1:0]     src_row,
  input logic [DIM_W-1:0]     src_col,
  input logic [PIX_W-1:0]     src_pixel_index,
  input logic [FILL_W-1:0]    pad_value
);

  // A held result keeps its payload until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_pad) && $stable(src_pixel_index)
      && $stable(src_batch) && $stable(pad_value))
    else $error("result changed while stalled");

  // With the output register empty the pipeline can always move, so input is taken.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output register");

  // Padding results carry no source coordinates.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_pad |-> src_batch == '0 && src_row == '0 && src_col == '0
      && src_pixel_index == '0)
    else $error("padding result with a source coordinate");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_pad |-> pad_value == '0)
    else $error("fill value on a non-padding result");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind space_to_batch_address_map s2b_checker u_s2b_checker (.*);
